// ===== design/hcp_pkg.sv =====
// Package for the Huffman code packer: field widths, op codes, shared types.
// No dependencies; used by hcp_table and huffman_code_packer.
`timescale 1ns / 1ps
`default_nettype none

package hcp_pkg;

  localparam int CodeW        = 32;  // code word field width
  localparam int LenW         = 6;   // code length field width
  localparam int SymW         = 8;   // symbol field width
  localparam int ByteW        = 8;
  localparam int PendW        = ByteW - 1;      // bits that can wait between items
  localparam int AccW         = PendW + CodeW;  // pending bits plus a full code
  localparam int CntW         = 6;              // holds 0..AccW

  localparam int DefMaxCodeLen = 32;
  localparam int DefNumSymbols = 256;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef logic [AccW-1:0] acc_t;

  // Registered table read result
  typedef struct packed {
    logic [CodeW-1:0] word;
    logic [LenW-1:0]  len;   // zero when the entry was never loaded
  } hcp_rd_t;

endpackage

`default_nettype wire

// ===== design/hcp_table.sv =====
// Code table: one synchronous memory of {code word, length} with a registered read,
// plus per-entry loaded flags so unloaded entries read as length zero. Uses hcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcp_table #(
  parameter int NUM_SYMBOLS = hcp_pkg::DefNumSymbols
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic                        rd_en_i,
  input  wire logic [$clog2(NUM_SYMBOLS)-1:0] addr_i,
  input  wire logic [hcp_pkg::CodeW-1:0]   wr_word_i,
  input  wire logic [hcp_pkg::LenW-1:0]    wr_len_i,
  output hcp_pkg::hcp_rd_t                 rd_o
);

  localparam int EntW = hcp_pkg::CodeW + hcp_pkg::LenW;

  logic [EntW-1:0]        mem [NUM_SYMBOLS];
  logic [EntW-1:0]        rd_data_q;
  logic [NUM_SYMBOLS-1:0] loaded_q;
  logic                   rd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= {wr_word_i, wr_len_i};
    end
    if (rd_en_i) begin
      rd_data_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        loaded_q[addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_hit_q <= loaded_q[addr_i];
      end
    end
  end

  assign rd_o.word = rd_data_q[EntW-1:hcp_pkg::LenW];
  assign rd_o.len  = rd_hit_q ? rd_data_q[hcp_pkg::LenW-1:0] : '0;

endmodule

`default_nettype wire

// ===== design/huffman_code_packer.sv =====
// Static Huffman encoder top level: table lookup stage, bit accumulator and
// byte emitter with an output register. Uses hcp_pkg and hcp_table.
//
//   port group     dir   handshake               word contents
//   in  channel    in    in_valid_i / in_stall_o   op, symbol, code_word, code_length
//   out channel    out   out_valid_o / out_stall_i out_byte, last_of_run
//
// An item is looked up in the code table the cycle it is taken and waits in the lookup stage
// until the accumulator has room for it; the accumulator emits one byte per cycle into the output
// register unless the output stalls. A code completing k bytes (1..4) keeps the accumulator busy
// until they drain; loads and short codes flow at one item per cycle unless the output stalls.
// Byte rate is bounded by the single output port. Reset clears the table's loaded flags, the pending
// bits and all valid flags at once. Output stall holds the output word and backs up into in_stall_o.
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_packer #(
  parameter int MAX_CODE_LEN = hcp_pkg::DefMaxCodeLen,
  parameter int NUM_SYMBOLS  = hcp_pkg::DefNumSymbols
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic [1:0]                op_i,
  input  wire logic [hcp_pkg::SymW-1:0]  symbol_i,
  input  wire logic [hcp_pkg::CodeW-1:0] code_word_i,
  input  wire logic [hcp_pkg::LenW-1:0]  code_length_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic [hcp_pkg::ByteW-1:0] out_byte_o,
  output      logic                      last_of_run_o
);

  localparam int AddrW  = $clog2(NUM_SYMBOLS);
  localparam int EffMax = (MAX_CODE_LEN < hcp_pkg::CodeW) ? MAX_CODE_LEN : hcp_pkg::CodeW;
  localparam int CntW   = hcp_pkg::CntW;
  localparam int PendW  = hcp_pkg::PendW;
  localparam logic [CntW-1:0] ByteCnt = CntW'(hcp_pkg::ByteW);

  logic in_acc, sym_ok, tbl_we, tbl_re;
  hcp_pkg::hcp_rd_t rd;

  // lookup stage
  logic s1_valid_q, s1_valid_d, s1_flush_q, s1_ok_q, s1_adv;

  // accumulator
  hcp_pkg::acc_t   acc_q, acc_d, code_masked, len_mask;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_r, code_len;
  logic [PendW-1:0] pend;
  logic [hcp_pkg::ByteW-1:0] flush_byte;
  logic            emit, s2_free;

  // output register
  logic                      out_valid_q, out_valid_d, out_free;
  logic [hcp_pkg::ByteW-1:0] out_byte_q, out_byte_d;
  logic                      out_last_q, out_last_d;

  assign in_acc = in_valid_i && !in_stall_o;
  assign sym_ok = 32'(symbol_i) < NUM_SYMBOLS;
  assign tbl_we = in_acc && (op_i == hcp_pkg::OP_LOAD) && sym_ok
                  && (code_length_i <= CntW'(EffMax));
  assign tbl_re = in_acc && (op_i == hcp_pkg::OP_ENCODE);

  hcp_table #(
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tbl_we),
    .rd_en_i   (tbl_re),
    .addr_i    (symbol_i[AddrW-1:0]),
    .wr_word_i (code_word_i),
    .wr_len_i  (code_length_i),
    .rd_o      (rd)
  );

  // Emit one byte from the top of the valid bits when the output slot frees up
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (cnt_q >= ByteCnt) && out_free;
  assign cnt_r    = emit ? (cnt_q - ByteCnt) : cnt_q;
  assign s2_free  = cnt_r < ByteCnt;
  assign s1_adv   = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = (op_i == hcp_pkg::OP_ENCODE) || (op_i == hcp_pkg::OP_FLUSH);
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
      s1_ok_q    <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_acc) begin
        s1_flush_q <= (op_i == hcp_pkg::OP_FLUSH);
        s1_ok_q    <= sym_ok;
      end
    end
  end

  // Merge: pending bits are the low cnt_r bits of the accumulator
  always_comb begin
    pend        = acc_q[PendW-1:0] & ((PendW'(1) << cnt_r[2:0]) - PendW'(1));
    code_len    = s1_ok_q ? rd.len : '0;
    len_mask    = (hcp_pkg::acc_t'(1) << code_len) - hcp_pkg::acc_t'(1);
    code_masked = hcp_pkg::acc_t'(rd.word) & len_mask;
    flush_byte  = hcp_pkg::ByteW'({1'b0, pend} << (ByteCnt - cnt_r));
    acc_d = acc_q;
    cnt_d = cnt_r;
    if (s1_adv) begin
      if (s1_flush_q) begin
        if (cnt_r != '0) begin
          acc_d = hcp_pkg::acc_t'(flush_byte);
          cnt_d = ByteCnt;
        end
      end else if (code_len != '0) begin
        acc_d = (hcp_pkg::acc_t'(pend) << code_len) | code_masked;
        cnt_d = cnt_r + code_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = hcp_pkg::ByteW'(acc_q >> (cnt_q - ByteCnt));
      out_last_d  = (cnt_q - ByteCnt) < ByteCnt;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(hcp_pkg::AccW))
    else $error("accumulator count beyond capacity");

  a_stall_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && (cnt_q >= ByteCnt))
    else $error("input stalled with nothing waiting to drain");

  a_more_after_nonlast : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |-> (cnt_q >= ByteCnt))
    else $error("non-final word with no further bytes pending");

  a_merge_after_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_re |=> s1_valid_q && !s1_flush_q)
    else $error("lookup issued without a matching stage entry");

endmodule

`default_nettype wire
